FILE: src/kcl_pkg.sv
// Shared types and constants for the key click / long / double classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kcl_pkg;

   // Register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_TICKS    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_CLICK_WINDOW = 1'd1;

   // Register reset values
   localparam logic [15:0] LONG_PRESS_TICKS_RST    = 16'd10;
   localparam logic [15:0] DOUBLE_CLICK_WINDOW_RST = 16'd5;

   // Counter widths and limits
   localparam int HOLD_W  = 16;
   localparam int WIN_W   = 16;
   localparam int CLICK_W = 8;
   localparam logic [CLICK_W-1:0] CLICK_MAX    = 8'd255;
   localparam logic [CLICK_W-1:0] DOUBLE_CLICKS = 8'd2;

   typedef enum logic [1:0] {
      OP_SCAN  = 2'd0,
      OP_GET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef struct packed {
      logic [15:0] long_press_ticks;
      logic [15:0] double_click_window;
   } cfg_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   pressed;
   } step_type;

   typedef struct packed {
      event_type event_res;
      logic      beep;
   } result_type;

endpackage

FILE: src/kcl_state.sv
// Classifier state registers and their per-request update.
// Depends on kcl_pkg for the operation and event codes and the step structs.
`timescale 1ns / 1ps

module kcl_state
   import kcl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  step_type   step,
   output result_type result
);

   logic               level_ff, level_in;
   logic [HOLD_W-1:0]  hold_count_ff, hold_count_in;
   logic [WIN_W-1:0]   window_count_ff, window_count_in;
   logic [CLICK_W-1:0] click_count_ff, click_count_in;
   event_type          event_latch_ff, event_latch_in;

   logic [HOLD_W-1:0]  hold_inc;
   logic [CLICK_W-1:0] click_mid;
   logic               beep;

   // Next state for one request
   always_comb begin
      level_in        = level_ff;
      hold_count_in   = hold_count_ff;
      window_count_in = window_count_ff;
      click_count_in  = click_count_ff;
      event_latch_in  = event_latch_ff;
      click_mid       = click_count_ff;
      beep            = 1'b0;
      hold_inc        = (hold_count_ff != '0) ? hold_count_ff + 1'b1 : hold_count_ff;

      if (step.valid) begin
         case (step.op)
            OP_SCAN: begin
               level_in = step.pressed;
               if (!level_ff && step.pressed) begin
                  // press edge: count the click, start the hold timer
                  click_mid     = (click_count_ff == CLICK_MAX) ? CLICK_MAX
                                                                : click_count_ff + 1'b1;
                  hold_count_in = {{(HOLD_W-1){1'b0}}, 1'b1};
                  beep          = 1'b1;
               end else if (level_ff && step.pressed) begin
                  // held: advance the hold timer, latch long at threshold
                  if (hold_inc >= cfg.long_press_ticks) begin
                     event_latch_in = EV_LONG;
                     hold_count_in  = '0;
                  end else begin
                     hold_count_in = hold_inc;
                  end
               end else if (level_ff && !step.pressed) begin
                  // release edge: classify the press
                  if (click_count_ff >= DOUBLE_CLICKS) begin
                     event_latch_in = EV_DOUBLE;
                  end else if (hold_count_ff != '0 &&
                               hold_count_ff < cfg.long_press_ticks) begin
                     event_latch_in = EV_CLICK;
                  end
               end
               click_count_in = click_mid;
               // released with clicks pending: run the window, drop on expiry
               if (click_mid != '0 && !step.pressed) begin
                  if (window_count_ff < cfg.double_click_window) begin
                     window_count_in = window_count_ff + 1'b1;
                  end else begin
                     window_count_in = '0;
                     click_count_in  = '0;
                  end
               end
            end
            OP_GET, OP_CLEAR: begin
               event_latch_in = EV_NONE;
            end
            default: begin
            end
         endcase
      end
   end

   // Result: latch before this request, beep on press edge
   always_comb begin
      result.event_res = event_latch_ff;
      result.beep      = beep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= 1'b0;
         hold_count_ff   <= '0;
         window_count_ff <= '0;
         click_count_ff  <= '0;
         event_latch_ff  <= EV_NONE;
      end else begin
         level_ff        <= level_in;
         hold_count_ff   <= hold_count_in;
         window_count_ff <= window_count_in;
         click_count_ff  <= click_count_in;
         event_latch_ff  <= event_latch_in;
      end
   end

`ifndef SYNTHESIS
   a_beep_means_pressed: assert property (@(posedge clock) disable iff (reset)
      result.beep |=> level_ff)
      else $error("beep without the level going to pressed");

   a_get_clears_latch: assert property (@(posedge clock) disable iff (reset)
      step.valid && (step.op == OP_GET || step.op == OP_CLEAR) |=> event_latch_ff == EV_NONE)
      else $error("event latch not cleared by get or clear");

   a_rsvd_no_change: assert property (@(posedge clock) disable iff (reset)
      step.valid && step.op == OP_RSVD |=>
         $stable(level_ff) && $stable(hold_count_ff) && $stable(click_count_ff)
         && $stable(window_count_ff) && $stable(event_latch_ff))
      else $error("reserved operation changed state");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step.valid |=> $stable(click_count_ff) && $stable(event_latch_ff))
      else $error("state changed without a request");
`endif

endmodule

FILE: src/key_click_long_double_classifier.sv
// Top level of the key click / long press / double click classifier.
// Depends on kcl_pkg and kcl_state.
`timescale 1ns / 1ps
//
//  channel  ports                               direction  accepted when
//  req      req_valid/ready, operation, pressed in         req_valid && req_ready
//  rsp      rsp_valid/ready, event_res, beep    out        rsp_valid && rsp_ready
//  csr      csr_we, csr_index, csr_wdata        in         csr_we
//
//  One request per cycle sustained while rsp_ready is high; each request is a
//  single pass from the input register through the state update into the
//  result register, where the result is registered.
//  Synchronous active-high reset clears all control and classifier state and
//  loads the register reset values. A stalled result holds in the output
//  register while one more request waits in the input register.

module key_click_long_double_classifier
   import kcl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_operation,
   input  logic                   req_pressed,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_event_res,
   output logic                   rsp_beep,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       s1_valid_ff, s1_valid_in;
   op_type     s1_op_ff;
   logic       s1_pressed_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   step_type   step;
   logic       advance;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LONG_PRESS_TICKS:    cfg_in.long_press_ticks    = csr_wdata;
            CSR_DOUBLE_CLICK_WINDOW: cfg_in.double_click_window = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance a request when the result register is free or draining
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign step.valid   = advance;
   assign step.op      = s1_op_ff;
   assign step.pressed = s1_pressed_ff;

   kcl_state u_state (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (step),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks    <= LONG_PRESS_TICKS_RST;
         cfg_ff.double_click_window <= DOUBLE_CLICK_WINDOW_RST;
         s1_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff      <= op_type'(req_operation);
         s1_pressed_ff <= req_pressed;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_ff.event_res;
   assign rsp_beep      = rsp_ff.beep;

endmodule

FILE: tb/key_click_long_double_classifier_tb.sv
// Self-checking testbench for the key click / long press / double click classifier:
// a directed table, then randomized button traffic under several register settings.
// Depends on kcl_pkg and key_click_long_double_classifier.
`timescale 1ns / 1ps

module key_click_long_double_classifier_tb;
   import kcl_pkg::*;

   // One row of the directed table; fixed rows carry a typed-in response
   typedef struct packed {
      op_type     op;
      logic       pressed;
      logic       fixed;
      result_type res;
   } dir_row_type;

   // Register setting and button timing for one random phase
   typedef struct {
      logic [15:0] long_ticks;
      logic [15:0] window;
      int          hold_max;
      int          rel_max;
      int          items;
      bit          steady;
   } phase_type;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_operation = OP_SCAN;
   logic                   req_pressed   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic [1:0]             rsp_event_res;
   logic                   rsp_beep;
   logic                   csr_we        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = CSR_LONG_PRESS_TICKS;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   // Request metadata held alongside the payload
   logic       fix_on  = 1'b0;
   result_type fix_res = '0;
   bit         steady  = 1'b0;
   int         errors  = 0;

   // Model copy of the registers and classifier state
   logic [15:0]        cfg_long_ticks = LONG_PRESS_TICKS_RST;
   logic [15:0]        cfg_window     = DOUBLE_CLICK_WINDOW_RST;
   logic               m_level        = 1'b0;
   logic [HOLD_W-1:0]  m_hold         = '0;
   logic [WIN_W-1:0]   m_window       = '0;
   logic [CLICK_W-1:0] m_clicks       = '0;
   event_type          m_latch        = EV_NONE;

   result_type pending_events [$];

   key_click_long_double_classifier DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_pressed   (req_pressed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_beep      (rsp_beep),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   // Advance the model by one request and return the response it gives
   function automatic result_type classify_request(op_type op, logic pressed);
      result_type res;
      logic       prev;
      res.event_res = m_latch;
      res.beep      = 1'b0;
      if (op == OP_SCAN) begin
         prev    = m_level;
         m_level = pressed;
         if (!prev && pressed) begin
            if (m_clicks != CLICK_MAX) m_clicks = m_clicks + 1'b1;
            m_hold   = HOLD_W'(1);
            res.beep = 1'b1;
         end else if (prev && pressed) begin
            if (m_hold != 0) m_hold = m_hold + 1'b1;
            if (m_hold >= cfg_long_ticks) begin
               m_latch = EV_LONG;
               m_hold  = '0;
            end
         end else if (prev && !pressed) begin
            if (m_clicks >= DOUBLE_CLICKS) m_latch = EV_DOUBLE;
            else if (m_hold != 0 && m_hold < cfg_long_ticks) m_latch = EV_CLICK;
         end
         // Run the window timer while released with clicks pending
         if (m_clicks != 0 && !pressed) begin
            if (m_window < cfg_window) begin
               m_window = m_window + 1'b1;
            end else begin
               m_window = '0;
               m_clicks = '0;
            end
         end
      end else if (op == OP_GET || op == OP_CLEAR) begin
         m_latch = EV_NONE;
      end
      return res;
   endfunction

   // Check responses first, then record the request accepted on this edge
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $error("response with no request pending");
               errors++;
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_res !== want.event_res) begin
                  $error("event_res expected %0d actual %0d", want.event_res, rsp_event_res);
                  errors++;
               end
               if (rsp_beep !== want.beep) begin
                  $error("beep expected %0d actual %0d", want.beep, rsp_beep);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = classify_request(op_type'(req_operation), req_pressed);
            if (fix_on) want = fix_res;
            pending_events.push_back(want);
         end
      end
   end

   // Stall the response side at random, except in steady stretches
   always @(negedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 12);
   end

   // Present one request, idling first at random, and hold it until accepted
   task automatic send(op_type op, logic pressed, logic fixed, result_type res);
      while (!steady && $urandom_range(0, 99) < 12) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_pressed   = pressed;
      fix_on        = fixed;
      fix_res       = res;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every pending response has come back
   task automatic drain();
      req_valid = 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_LONG_PRESS_TICKS) cfg_long_ticks = val;
      else cfg_window = val;
   endtask

   initial begin
      dir_row_type rows [25];
      phase_type   phases [6];
      phase_type   ph;
      logic        btn_level;
      int          btn_left;
      int          r;
      logic        lvl;

      // Default registers: long press after 10 held ticks, window of 5
      rows = '{
         '{OP_GET,   1'b0, 1'b1, '{EV_NONE, 1'b0}},  // empty latch after reset
         '{OP_RSVD,  1'b1, 1'b1, '{EV_NONE, 1'b0}},  // unused code is ignored
         '{OP_CLEAR, 1'b1, 1'b1, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b1, '{EV_NONE, 1'b1}},  // first press edge beeps
         '{OP_SCAN,  1'b0, 1'b0, '{EV_NONE, 1'b0}},  // short release: click
         '{OP_GET,   1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},  // second press in window
         '{OP_SCAN,  1'b0, 1'b0, '{EV_NONE, 1'b0}},  // release: double
         '{OP_RSVD,  1'b0, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b0, 1'b0, '{EV_NONE, 1'b0}},  // run the window out
         '{OP_SCAN,  1'b0, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b0, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b0, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},  // hold through long press
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b1, 1'b0, '{EV_NONE, 1'b0}},
         '{OP_SCAN,  1'b0, 1'b0, '{EV_NONE, 1'b0}},  // release after long: no click
         '{OP_GET,   1'b0, 1'b0, '{EV_NONE, 1'b0}}
      };

      // Register extremes and button timing per phase; phase 1 saturates clicks
      phases[0] = '{16'd2,     16'd0,     4, 3, 300, 1'b0};
      phases[1] = '{16'hFFFF,  16'hFFFF,  1, 1, 700, 1'b1};
      phases[2] = '{16'd0,     16'd3,     5, 6, 200, 1'b0};
      phases[3] = '{16'd1,     16'd1,     4, 4, 200, 1'b0};
      phases[4] = '{16'd2,     16'd0,     6, 4, 300, 1'b0};
      phases[5] = '{LONG_PRESS_TICKS_RST, DOUBLE_CLICK_WINDOW_RST, 14, 9, 300, 1'b0};
      phases[4].long_ticks = 16'($urandom_range(2, 20));
      phases[4].window     = 16'($urandom_range(0, 12));
      phases[4].hold_max   = phases[4].long_ticks + 4;
      phases[4].rel_max    = phases[4].window + 4;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send(rows[i].op, rows[i].pressed, rows[i].fixed, rows[i].res);
      drain();

      btn_level = m_level;
      btn_left  = 0;
      foreach (phases[p]) begin
         ph = phases[p];
         write_csr(CSR_LONG_PRESS_TICKS, ph.long_ticks);
         write_csr(CSR_DOUBLE_CLICK_WINDOW, ph.window);
         steady = ph.steady;
         for (int n = 0; n < ph.items; n++) begin
            // Hold off the sender once until the block has emptied
            if (p == 0 && n == 150) drain();
            r = $urandom_range(0, 99);
            if (r < 8) begin
               send(OP_GET, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (r < 12) begin
               send(OP_CLEAR, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (r < 15) begin
               send(OP_RSVD, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               // Follow the button model, with a little level noise
               if (btn_left == 0) begin
                  btn_level = !btn_level;
                  btn_left  = btn_level ? $urandom_range(1, ph.hold_max)
                                        : $urandom_range(1, ph.rel_max);
               end
               btn_left--;
               lvl = ($urandom_range(0, 99) < 4) ? 1'($urandom_range(0, 1)) : btn_level;
               send(OP_SCAN, lvl, 1'b0, '0);
            end
         end
         drain();
         steady = 1'b0;
      end

      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #1000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
src/kcl_pkg.sv
src/kcl_state.sv
src/key_click_long_double_classifier.sv
tb/key_click_long_double_classifier_tb.sv
